/* hw/rtl/bitmap_run_allocator_assert.svh */
// Assertion macros used by the bitmap allocator RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef BITMAP_RUN_ALLOCATOR_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bitmap allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bitmap allocator assertion failed");

`endif

/* hw/rtl/bra_pkg.sv */
// Shared types and constants for the bitmap run allocator.
// No dependencies; imported by the top level.
`default_nettype none

package bra_pkg;

	// Request codes carried on the func port.
	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_SCAN  = 2'd1,
		FUNC_TEST  = 2'd2,
		FUNC_WRITE = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_TEST,
		ST_WRITE,
		ST_FINISH
	} state_t;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned INDEX_W    = 10;
	localparam int unsigned RUN_W      = 11;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_ADDR_W = 3;

	// Register index taken from the word address bit of paddr.
	localparam logic REG_MAP_BYTES = 1'b0;
	localparam logic [BYTE_W-1:0] MAP_BYTES_RESET = 8'd128;

endpackage

`default_nettype wire

/* hw/rtl/bitmap_run_allocator.sv */
// Bitmap run allocator: first-fit search for runs of free bits in a byte-wide map.
// Depends on bra_pkg, bra_ram and bitmap_run_allocator_assert.svh.
//
// Usage:
//   A request is transferred at a rising edge where start is high and busy is low.
//   func selects clear (0), scan for a run of run_length free bits (1), test the
//   bit at bit_index (2) or write bit_value to the bit at bit_index (3).
//   Every request gives one result: done is high for exactly one cycle with
//   found, start_index and bit_read. The receiver cannot stall; a result that is
//   not taken in its cycle is gone. A new request may be transferred in the
//   cycle in which the previous result is shown.
//   Test and write read the addressed byte, then answer or write it back. Clear
//   writes zero to each used byte, where used = min(map_bytes, MAX_BYTES), and
//   answers without leaving idle when used is zero. A scan reads one byte per
//   cycle through the map memory's read port and checks its eight bits in one
//   step; it answers from idle when the run length is zero or longer than the map.
//   The map_bytes register sits on the APB port at byte address 0 and must be
//   written only while the block is idle; the block itself does not enforce it.
//   After reset the block is busy while it writes zero to every byte of the map,
//   one byte per cycle; register writes are taken then.
`default_nettype none

module bitmap_run_allocator
	import bra_pkg::*;
#(
	parameter int unsigned MAX_BYTES = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            func,
	input  wire logic [INDEX_W-1:0]    bit_index,
	input  wire logic [RUN_W-1:0]      run_length,
	input  wire logic                  bit_value,
	output logic                       done,
	output logic                       found,
	output logic [INDEX_W-1:0]         start_index,
	output logic                       bit_read,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	`include "bitmap_run_allocator_assert.svh"

	localparam int unsigned AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int unsigned CW0 = $clog2(MAX_BYTES + 1);
	localparam int unsigned CW  = (CW0 > 9) ? CW0 : 9;
	localparam logic [12:0]   MAXB = 13'(MAX_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BYTES);

	state_t state_q, state_d;

	logic [BYTE_W-1:0]  map_bytes_q;
	logic [1:0]         func_q;
	logic [INDEX_W-1:0] idx_q;
	logic [RUN_W-1:0]   len_q;
	logic               val_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      dbyte_q;
	logic               dv_q;
	logic [RUN_W-1:0]   run_q;
	logic [RUN_W-1:0]   end_q;
	logic               done_q;
	logic               found_q;
	logic [INDEX_W-1:0] start_q;
	logic               bitrd_q;

	logic [BYTE_W-1:0]  used;
	logic [CW-1:0]      used_c;
	logic [RUN_W-1:0]   total;
	logic               accept;
	logic               cfg_write;
	logic               idx_in_range;
	logic               req_in_range;
	logic [BYTE_W-1:0]  bit_mask;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [BYTE_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [BYTE_W-1:0]  ram_rdata;

	logic               cnt_clr;
	logic               cnt_inc;
	logic               scan_issue;
	logic               run_clr;
	logic               emit;
	logic               res_found;
	logic [INDEX_W-1:0] res_start;
	logic               res_bitrd;

	logic               hit;
	logic [2:0]         hit_j;
	logic [RUN_W-1:0]   run_next;
	logic               scan_last;
	logic [RUN_W:0]     start_full;

	// Effective map length, clipped to the store.
	always_comb begin
		if ({5'b0, map_bytes_q} > MAXB) begin
			used = MAXB[BYTE_W-1:0];
		end else begin
			used = map_bytes_q;
		end
	end

	assign used_c       = CW'(used);
	assign total        = {used, 3'b000};
	assign accept       = start && !busy;
	assign cfg_write    = psel && penable && pwrite && pready;
	assign idx_in_range = {6'b0, bit_index[INDEX_W-1:3]} < MAXB;
	assign req_in_range = {6'b0, idx_q[INDEX_W-1:3]} < MAXB;
	assign bit_mask     = BYTE_W'(1) << idx_q[2:0];
	assign scan_last    = (dbyte_q == used_c - CW'(1));
	assign start_full   = {1'b0, end_q} + (RUN_W + 1)'(1) - {1'b0, len_q};

	// Walks the eight bits of one map byte, carrying the running count of free bits.
	always_comb begin
		logic [RUN_W-1:0] r;
		logic             h;
		logic [2:0]       hj;
		r  = run_q;
		h  = 1'b0;
		hj = 3'd0;
		for (int j = 0; j < 8; j++) begin
			if (!h) begin
				if (!ram_rdata[j]) begin
					r = r + RUN_W'(1);
					if (r == len_q) begin
						h  = 1'b1;
						hj = 3'(j);
					end
				end else begin
					r = '0;
				end
			end
		end
		hit      = h;
		hit_j    = hj;
		run_next = r;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == MAXC - CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_CLEAR: begin
							if (used != '0) begin
								state_d = ST_CLEAR;
							end
						end
						FUNC_SCAN: begin
							if (run_length != '0 && run_length <= total) begin
								state_d = ST_SCAN;
							end
						end
						FUNC_TEST:  state_d = ST_TEST;
						FUNC_WRITE: state_d = ST_WRITE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (cnt_q == used_c - CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (dv_q && hit) begin
					state_d = ST_FINISH;
				end else if (dv_q && scan_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_TEST:   state_d = ST_IDLE;
			ST_WRITE:  state_d = ST_IDLE;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_INIT;
		endcase
	end

	// Datapath and memory controls.
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = cnt_q[AW-1:0];
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = cnt_q[AW-1:0];
		cnt_clr    = 1'b0;
		cnt_inc    = 1'b0;
		scan_issue = 1'b0;
		run_clr    = 1'b0;
		emit       = 1'b0;
		res_found  = 1'b1;
		res_start  = '0;
		res_bitrd  = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we  = 1'b1;
				cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				cnt_clr = 1'b1;
				run_clr = 1'b1;
				if (accept) begin
					case (func)
						FUNC_CLEAR: begin
							emit = (used == '0);
						end
						FUNC_SCAN: begin
							if (run_length == '0 || run_length > total) begin
								emit      = 1'b1;
								res_found = 1'b0;
							end
						end
						FUNC_TEST, FUNC_WRITE: begin
							ram_re    = idx_in_range;
							ram_raddr = AW'(bit_index[INDEX_W-1:3]);
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				ram_we  = 1'b1;
				cnt_inc = 1'b1;
				emit    = (cnt_q == used_c - CW'(1));
			end
			ST_SCAN: begin
				if (cnt_q < used_c) begin
					scan_issue = 1'b1;
					ram_re     = 1'b1;
					cnt_inc    = 1'b1;
				end
				if (dv_q && !hit && scan_last) begin
					emit      = 1'b1;
					res_found = 1'b0;
				end
			end
			ST_TEST: begin
				emit      = 1'b1;
				res_bitrd = req_in_range && ram_rdata[idx_q[2:0]];
			end
			ST_WRITE: begin
				emit      = 1'b1;
				ram_we    = req_in_range;
				ram_waddr = AW'(idx_q[INDEX_W-1:3]);
				if (val_q) begin
					ram_wdata = ram_rdata | bit_mask;
				end else begin
					ram_wdata = ram_rdata & ~bit_mask;
				end
			end
			ST_FINISH: begin
				emit      = 1'b1;
				res_start = start_full[INDEX_W-1:0];
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			map_bytes_q <= MAP_BYTES_RESET;
			cnt_q       <= '0;
			dv_q        <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && paddr[2] == REG_MAP_BYTES) begin
				map_bytes_q <= pwdata[BYTE_W-1:0];
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			dv_q   <= scan_issue;
			done_q <= emit;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			idx_q  <= bit_index;
			len_q  <= run_length;
			val_q  <= bit_value;
		end
		dbyte_q <= cnt_q;
		if (run_clr) begin
			run_q <= '0;
		end else if (dv_q) begin
			run_q <= run_next;
		end
		if (state_q == ST_SCAN && dv_q && hit) begin
			end_q <= {dbyte_q[BYTE_W-1:0], hit_j};
		end
		if (emit) begin
			found_q <= res_found;
			start_q <= res_start;
			bitrd_q <= res_bitrd;
		end
	end

	bra_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_BYTES)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign start_index = start_q;
	assign bit_read    = bitrd_q;
	assign pready      = 1'b1;
	assign prdata      = (paddr[2] == REG_MAP_BYTES) ? {24'b0, map_bytes_q} : '0;

	// A transfer either answers at once or keeps the block busy.
	`BRA_ASSERT_NEXT(a_accept_progress, clk, arst_n, accept, busy || done)
	// Results are only presented once the sequencer is back in idle.
	`BRA_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	// A failed scan reports nothing else.
	`BRA_ASSERT_SAME(a_notfound_zero, clk, arst_n, done && !found,
		start_index == '0 && bit_read == 1'b0)
	// The map is written only by the reset sweep, a clear or a bit write.
	`BRA_ASSERT_SAME(a_write_source, clk, arst_n, ram_we,
		state_q == ST_INIT || state_q == ST_CLEAR || state_q == ST_WRITE)
	// func_q is only consulted through the state it selected.
	`BRA_ASSERT_SAME(a_test_func, clk, arst_n, state_q == ST_TEST, func_q == FUNC_TEST)

endmodule

`default_nettype wire

/* hw/rtl/bra_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* verif/tb_bitmap_run_allocator.sv */
// Self-checking testbench for bitmap_run_allocator: directed and random requests, APB map length.
// Depends on bra_pkg and the RTL of the allocator; expected results come from an in-bench model.
`default_nettype none

module tb_bitmap_run_allocator;
	import bra_pkg::*;

	localparam int MAP_DEPTH = 128;
	localparam logic [CFG_ADDR_W-1:0] MAP_BYTES_ADDR = {REG_MAP_BYTES, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] NO_REG_ADDR = 3'd4;

	typedef enum logic [1:0] {
		ITEM_REQ,
		ITEM_CFG,
		ITEM_DRAIN
	} item_kind_t;

	typedef struct packed {
		item_kind_t             kind;
		func_t                  func;
		logic [INDEX_W-1:0]     bit_index;
		logic [RUN_W-1:0]       run_length;
		logic                   bit_value;
		logic [CFG_ADDR_W-1:0]  addr;
		logic [CFG_DATA_W-1:0]  data;
		logic [7:0]             gap;
	} item_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] start_index;
		logic               bit_read;
	} outcome_t;

	typedef enum logic [2:0] {
		P_NONE,
		P_HOLD,
		P_REQ,
		P_SETUP,
		P_ACCESS
	} drv_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	func_t func = FUNC_CLEAR;
	logic [INDEX_W-1:0] bit_index = '0;
	logic [RUN_W-1:0] run_length = '0;
	logic bit_value = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic busy;
	logic done;
	logic found;
	logic [INDEX_W-1:0] start_index;
	logic bit_read;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	bitmap_run_allocator #(
		.MAX_BYTES(MAP_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.bit_index(bit_index),
		.run_length(run_length),
		.bit_value(bit_value),
		.done(done),
		.found(found),
		.start_index(start_index),
		.bit_read(bit_read),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Model state: the bitmap and the map length register.
	logic [BYTE_W-1:0] alloc_map [MAP_DEPTH];
	logic [BYTE_W-1:0] map_len = MAP_BYTES_RESET;

	item_t pending_q[$];
	outcome_t outcome_q[$];
	item_t cur;
	drv_phase_t phase = P_NONE;
	int gap_left = 0;
	int error_count = 0;
	bit calm = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_error(string msg);
		error_count++;
		if (error_count <= 100)
			$display("mismatch: %s", msg);
	endtask

	function automatic int used_bytes();
		return (map_len > MAP_DEPTH) ? MAP_DEPTH : int'(map_len);
	endfunction

	function automatic logic map_bit(int idx);
		if ((idx >> 3) >= MAP_DEPTH)
			return 1'b0;
		return alloc_map[idx >> 3][idx & 7];
	endfunction

	// Applies one request to the model bitmap and returns what the block must answer.
	function automatic outcome_t serve_request(item_t it);
		outcome_t o;
		int total;
		int run;
		int len;
		int idx;
		bit hit;
		o.found = 1'b1;
		o.start_index = '0;
		o.bit_read = 1'b0;
		len = int'(it.run_length);
		idx = int'(it.bit_index);
		case (it.func)
			FUNC_CLEAR: begin
				for (int b = 0; b < used_bytes(); b++)
					alloc_map[b] = '0;
			end
			FUNC_SCAN: begin
				total = used_bytes() * 8;
				run = 0;
				hit = 1'b0;
				o.found = 1'b0;
				if (len != 0 && len <= total) begin
					for (int i = 0; i < total && !hit; i++) begin
						if (map_bit(i) == 1'b0) begin
							run++;
							if (run == len) begin
								hit = 1'b1;
								o.found = 1'b1;
								o.start_index = INDEX_W'(i + 1 - len);
							end
						end else begin
							run = 0;
						end
					end
				end
			end
			FUNC_TEST: o.bit_read = map_bit(idx);
			default: begin
				if ((idx >> 3) < MAP_DEPTH)
					alloc_map[idx >> 3][idx & 7] = it.bit_value;
			end
		endcase
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_req(func_t f, int idx, int len, bit val);
		item_t it;
		it = '0;
		it.kind = ITEM_REQ;
		it.func = f;
		it.bit_index = INDEX_W'(idx);
		it.run_length = RUN_W'(len);
		it.bit_value = val;
		it.gap = calm ? 8'd0 : 8'(pick_gap());
		pending_q.push_back(it);
	endtask

	task automatic push_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		item_t it;
		it = '0;
		it.kind = ITEM_CFG;
		it.func = FUNC_CLEAR;
		it.addr = addr;
		it.data = data;
		pending_q.push_back(it);
	endtask

	task automatic push_drain();
		item_t it;
		it = '0;
		it.kind = ITEM_DRAIN;
		it.func = FUNC_CLEAR;
		pending_q.push_back(it);
	endtask

	// One setting of the map length followed by a random mix of requests.
	task automatic random_phase(int n_items, int len_bytes, bit force_drain);
		int used;
		int bits;
		int cap;
		int fill_bias;
		int r;
		int s;
		int idx;
		int len;
		used = (len_bytes > MAP_DEPTH) ? MAP_DEPTH : len_bytes;
		bits = used * 8;
		cap = (bits < 16) ? bits : 16;
		fill_bias = $urandom_range(20, 85);
		calm = ($urandom_range(0, 3) == 0);
		push_cfg(MAP_BYTES_ADDR, ($urandom() & 32'hffff_ff00) | CFG_DATA_W'(len_bytes));
		for (int k = 0; k < n_items; k++) begin
			if (k == n_items / 2 && (force_drain || $urandom_range(0, 1) == 1))
				push_drain();
			r = $urandom_range(0, 99);
			if (bits > 0 && $urandom_range(0, 9) < 8)
				idx = $urandom_range(0, bits - 1);
			else
				idx = $urandom_range(0, 1023);
			if (r < 4) begin
				push_req(FUNC_CLEAR, idx, $urandom_range(0, 2047), $urandom_range(0, 1));
			end else if (r < 48) begin
				push_req(FUNC_WRITE, idx, $urandom_range(0, 2047),
					$urandom_range(0, 99) < fill_bias);
			end else if (r < 66) begin
				push_req(FUNC_TEST, idx, $urandom_range(0, 2047), $urandom_range(0, 1));
			end else begin
				s = $urandom_range(0, 19);
				if (bits == 0)
					len = $urandom_range(0, 8);
				else if (s == 0)
					len = 0;
				else if (s == 1)
					len = $urandom_range(bits + 1, 2047);
				else if (s == 2)
					len = bits;
				else if (s < 5)
					len = $urandom_range(1, bits);
				else
					len = $urandom_range(1, cap);
				push_req(FUNC_SCAN, idx, len, $urandom_range(0, 1));
			end
		end
	endtask

	// Driver: one transfer per request, APB writes only while nothing is outstanding.
	always @(posedge clk) begin : drive
		logic n_start;
		logic n_psel;
		logic n_penable;
		logic n_pwrite;
		logic launch;
		n_start = start;
		n_psel = psel;
		n_penable = penable;
		n_pwrite = pwrite;
		launch = 1'b0;
		if (arst_n) begin
			case (phase)
				P_REQ: begin
					if (start && !busy) begin
						outcome_q.push_back(serve_request(cur));
						n_start = 1'b0;
						phase = P_NONE;
					end
				end
				P_SETUP: begin
					n_penable = 1'b1;
					phase = P_ACCESS;
				end
				P_ACCESS: begin
					if (pready) begin
						if (paddr == MAP_BYTES_ADDR)
							map_len = pwdata[BYTE_W-1:0];
						n_psel = 1'b0;
						n_penable = 1'b0;
						n_pwrite = 1'b0;
						phase = P_NONE;
					end
				end
				P_HOLD: begin
					gap_left--;
					if (gap_left == 0)
						launch = 1'b1;
				end
				default: ;
			endcase
			// A result shown in this cycle still counts as outstanding, so the
			// idle test does not depend on the monitor running first.
			if (phase == P_NONE && pending_q.size() != 0) begin
				case (pending_q[0].kind)
					ITEM_REQ: begin
						cur = pending_q.pop_front();
						if (cur.gap == 0) begin
							launch = 1'b1;
						end else begin
							gap_left = int'(cur.gap);
							phase = P_HOLD;
						end
					end
					ITEM_CFG: begin
						if (outcome_q.size() == 0 && !done) begin
							cur = pending_q.pop_front();
							paddr <= cur.addr;
							pwdata <= cur.data;
							n_psel = 1'b1;
							n_pwrite = 1'b1;
							phase = P_SETUP;
						end
					end
					default: begin
						if (outcome_q.size() == 0 && !done)
							void'(pending_q.pop_front());
					end
				endcase
			end
			if (launch) begin
				n_start = 1'b1;
				func <= cur.func;
				bit_index <= cur.bit_index;
				run_length <= cur.run_length;
				bit_value <= cur.bit_value;
				phase = P_REQ;
			end
		end
		start <= n_start;
		psel <= n_psel;
		penable <= n_penable;
		pwrite <= n_pwrite;
	end

	// Monitor: every result strobe is matched against the oldest expectation.
	always @(posedge clk) begin : watch
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				note_error($sformatf("unexpected result found=%0d start_index=%0d bit_read=%0d",
					found, start_index, bit_read));
			end else begin
				want = outcome_q.pop_front();
				if (found !== want.found)
					note_error($sformatf("found %0d, expected %0d", found, want.found));
				if (start_index !== want.start_index)
					note_error($sformatf("start_index %0d, expected %0d",
						start_index, want.start_index));
				if (bit_read !== want.bit_read)
					note_error($sformatf("bit_read %0d, expected %0d", bit_read, want.bit_read));
			end
		end
	end

	initial begin
		#12_000_000;
		$display("tb_bitmap_run_allocator: errors");
		$finish;
	end

	initial begin : main
		int phase_len [12];
		int len_bytes;
		for (int b = 0; b < MAP_DEPTH; b++)
			alloc_map[b] = '0;
		phase_len = '{128, 1, 16, 0, 255, 2, -1, 64, -2, 128, 5, -1};

		// Directed part, starting from the reset value of the map length.
		push_req(FUNC_SCAN, 0, 1, 0);
		push_req(FUNC_SCAN, 1023, 0, 1);
		push_req(FUNC_SCAN, 0, 1024, 0);
		push_req(FUNC_SCAN, 0, 2047, 0);
		push_req(FUNC_WRITE, 0, 0, 1);
		push_req(FUNC_TEST, 0, 0, 0);
		push_req(FUNC_WRITE, 1023, 2047, 1);
		push_req(FUNC_TEST, 1023, 0, 0);
		push_req(FUNC_SCAN, 0, 1024, 0);
		push_req(FUNC_SCAN, 0, 1022, 0);
		push_req(FUNC_WRITE, 1023, 0, 0);
		push_req(FUNC_SCAN, 0, 1023, 0);
		// One byte in use; the upper data bits must not reach the register.
		push_cfg(MAP_BYTES_ADDR, 32'hffff_ff01);
		push_req(FUNC_SCAN, 0, 7, 0);
		push_req(FUNC_SCAN, 0, 9, 0);
		push_req(FUNC_WRITE, 600, 0, 1);
		push_req(FUNC_TEST, 600, 0, 0);
		push_req(FUNC_CLEAR, 0, 0, 0);
		push_req(FUNC_TEST, 0, 0, 0);
		push_req(FUNC_TEST, 600, 0, 0);
		// Empty map: scans fail and clear leaves the store alone.
		push_cfg(MAP_BYTES_ADDR, 32'h0000_0000);
		push_req(FUNC_SCAN, 0, 1, 0);
		push_req(FUNC_WRITE, 1, 0, 1);
		push_req(FUNC_CLEAR, 0, 0, 0);
		push_req(FUNC_TEST, 1, 0, 0);
		push_cfg(NO_REG_ADDR, 32'h0000_0005);
		push_req(FUNC_SCAN, 0, 1, 0);
		// Oversized length behaves as the full store.
		push_cfg(MAP_BYTES_ADDR, 32'h0000_00ff);
		push_req(FUNC_SCAN, 0, 1024, 0);

		for (int p = 0; p < 12; p++) begin
			len_bytes = phase_len[p];
			if (len_bytes == -1)
				len_bytes = $urandom_range(3, 127);
			else if (len_bytes == -2)
				len_bytes = $urandom_range(129, 255);
			random_phase((len_bytes == 0) ? 40 : 110, len_bytes, p == 0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() == 0 && phase == P_NONE && outcome_q.size() == 0);
		repeat (200) @(posedge clk);
		if (outcome_q.size() != 0)
			note_error($sformatf("%0d results never arrived", outcome_q.size()));
		if (error_count == 0)
			$display("tb_bitmap_run_allocator: clean");
		else
			$display("tb_bitmap_run_allocator: errors");
		$finish;
	end

endmodule

`default_nettype wire

/* bitmap_run_allocator.f */
+incdir+hw/rtl
hw/rtl/bra_pkg.sv
hw/rtl/bra_ram.sv
hw/rtl/bitmap_run_allocator.sv
verif/tb_bitmap_run_allocator.sv
